// File: sv/spq_pkg.sv
// Shared types and constants for the stable priority queue.
// Used by spq_ctrl, spq_datapath and stable_priority_queue_unit; no dependencies.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int PRIO_BITS   = 8;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_BITS    = 5;
  localparam int STATUS_BITS = 2;

  // Operation codes carried on the kind field.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    SC_ENQUEUED = 2'd0,
    SC_DEQUEUED = 2'd1,
    SC_EMPTY    = 2'd2,
    SC_FULL     = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    enq;
    logic    deq;
    logic    load;
    status_e code;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

// File: sv/spq_ctrl.sv
// Controller of the stable priority queue: handshakes and operation decode.
// Depends on spq_pkg.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     kind_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // A held result that is not being taken blocks the next item.
  assign in_stall_o  = (state_q == ST_HOLD) && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_HOLD);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (accept) state_d = ST_HOLD;
        else if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o.load = accept;
    cmd_o.enq  = accept && (kind_i == OP_ENQ) && !stat_i.full;
    cmd_o.deq  = accept && (kind_i == OP_DEQ) && !stat_i.empty;
    if (kind_i == OP_ENQ) begin
      cmd_o.code = stat_i.full ? SC_FULL : SC_ENQUEUED;
    end else begin
      cmd_o.code = stat_i.empty ? SC_EMPTY : SC_DEQUEUED;
    end
  end

endmodule

// File: sv/spq_datapath.sv
// Datapath of the stable priority queue: shifting sorted entry array,
// entry count and result register. Depends on spq_pkg.
module spq_datapath
  import spq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  input  logic [ID_BITS-1:0]     proc_id_i,
  input  logic [PRIO_BITS-1:0]   priority_req_i,
  output dp_stat_t               stat_o,
  output logic [STATUS_BITS-1:0] status_o,
  output logic [ID_BITS-1:0]     out_id_o,
  output logic [PRIO_BITS-1:0]   out_priority_o,
  output logic [OCC_BITS-1:0]    occupancy_o
);

  logic [ID_BITS-1:0]   id_q   [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] prio_q [QUEUE_DEPTH];
  logic [CNT_BITS-1:0]  count_q, count_d;
  logic [QUEUE_DEPTH-1:0] stay;

  logic [STATUS_BITS-1:0] status_q;
  logic [ID_BITS-1:0]     out_id_q;
  logic [PRIO_BITS-1:0]   out_prio_q;
  logic [OCC_BITS-1:0]    occ_q;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CNT_BITS'(QUEUE_DEPTH));

  always_comb begin
    count_d = count_q;
    if (cmd_i.enq) count_d = count_q + CNT_BITS'(1);
    else if (cmd_i.deq) count_d = count_q - CNT_BITS'(1);
  end

  // Held entries of equal or higher priority stay put; the array is sorted,
  // so these form a prefix and the new item lands right after it.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    assign stay[i] = (CNT_BITS'(i) < count_q) && (prio_q[i] >= priority_req_i);

    always_ff @(posedge clk_i) begin
      if (cmd_i.enq && !stay[i]) begin
        if (i == 0) begin
          id_q[i]   <= proc_id_i;
          prio_q[i] <= priority_req_i;
        end else if (stay[(i == 0) ? 0 : i-1]) begin
          id_q[i]   <= proc_id_i;
          prio_q[i] <= priority_req_i;
        end else begin
          id_q[i]   <= id_q[(i == 0) ? 0 : i-1];
          prio_q[i] <= prio_q[(i == 0) ? 0 : i-1];
        end
      end else if (cmd_i.deq && (i < QUEUE_DEPTH - 1)) begin
        id_q[i]   <= id_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
        prio_q[i] <= prio_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q   <= cmd_i.code;
      out_id_q   <= cmd_i.deq ? id_q[0] : '0;
      out_prio_q <= cmd_i.deq ? prio_q[0] : '0;
      occ_q      <= OCC_BITS'(count_d);
    end
  end

  assign status_o       = status_q;
  assign out_id_o       = out_id_q;
  assign out_priority_o = out_prio_q;
  assign occupancy_o    = occ_q;

endmodule

// File: sv/stable_priority_queue_unit.sv
// Stable priority queue unit: top level joining controller and datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// Holds up to QUEUE_DEPTH (id, priority) entries sorted by priority, highest
// first, with equal priorities kept in arrival order. Each item is an enqueue
// or a dequeue and produces exactly one result item with a status code, the
// dequeued entry (zero otherwise) and the occupancy after the operation. The
// insertion point is found by comparing every slot in parallel and the whole
// array shifts in the same cycle, so a new item is accepted every cycle as
// long as the result register is drained. The result is registered and
// appears in the cycle after its item is accepted.
module stable_priority_queue_unit
  import spq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   kind_i,
  input  logic [ID_BITS-1:0]     proc_id_i,
  input  logic [PRIO_BITS-1:0]   priority_req_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [STATUS_BITS-1:0] status_o,
  output logic [ID_BITS-1:0]     out_id_o,
  output logic [PRIO_BITS-1:0]   out_priority_o,
  output logic [OCC_BITS-1:0]    occupancy_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .proc_id_i      (proc_id_i),
    .priority_req_i (priority_req_i),
    .stat_o         (stat),
    .status_o       (status_o),
    .out_id_o       (out_id_o),
    .out_priority_o (out_priority_o),
    .occupancy_o    (occupancy_o)
  );

endmodule
